// ===== design/hvd_pkg.sv =====
// shared types and constants of the hblank vram dma engine
// no dependencies; used by every other file but the channel interfaces and the port checker
`timescale 1ns / 1ps

package hvd_pkg;

  localparam int unsigned VRAM_END_DEF    = 40960;
  localparam int unsigned BLOCK_BYTES_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_HBLANK = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [7:0] STATUS_DONE  = 8'hFF;
  localparam logic [2:0] VRAM_BASE_HI = 3'b100;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_HBLANK,
    CMD_TICK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  control_byte;
    logic [15:0] source_address;
    logic [12:0] dest_offset;
    logic        double_speed;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

// ===== design/hvd_in_if.sv =====
// input channel of the dma engine: valid/ready plus one input word
// no dependencies
`timescale 1ns / 1ps

interface hvd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  control_byte;
  logic [15:0] source_address;
  logic [12:0] dest_offset;
  logic        double_speed;

  modport source (output valid, op, control_byte, source_address, dest_offset,
                  double_speed, input ready);
  modport sink (input valid, op, control_byte, source_address, dest_offset,
                double_speed, output ready);
endinterface

// ===== design/hvd_out_if.sv =====
// output channel of the dma engine: valid/ready plus one result word
// no dependencies
`timescale 1ns / 1ps

interface hvd_out_if;
  logic        valid;
  logic        ready;
  logic        copy_valid;
  logic [15:0] copy_source;
  logic [15:0] copy_dest;
  logic        status_write;
  logic [7:0]  status_value;
  logic        last;

  modport source (output valid, copy_valid, copy_source, copy_dest, status_write,
                  status_value, last, input ready);
  modport sink (input valid, copy_valid, copy_source, copy_dest, status_write,
                status_value, last, output ready);
endinterface

// ===== design/hvd_front.sv =====
// front end: takes input words and decodes them into queued commands
// depends on hvd_pkg and hvd_in_if
`timescale 1ns / 1ps

module hvd_front (
  hvd_in_if.sink        in_i,
  input  logic          q_full_i,
  output hvd_pkg::push_t push_o
);

  logic            take;
  logic            known;
  hvd_pkg::cmd_kind_e kind;

  assign in_i.ready = !q_full_i;
  assign take       = in_i.valid && !q_full_i;

  always_comb begin
    known = 1'b1;
    kind  = hvd_pkg::CMD_TICK;
    unique case (in_i.op)
      hvd_pkg::OP_START:  kind = hvd_pkg::CMD_START;
      hvd_pkg::OP_HBLANK: kind = hvd_pkg::CMD_HBLANK;
      hvd_pkg::OP_TICK:   kind = hvd_pkg::CMD_TICK;
      // unused opcode is swallowed here
      default:            known = 1'b0;
    endcase
  end

  always_comb begin
    push_o.push               = take && known;
    push_o.cmd.kind           = kind;
    push_o.cmd.control_byte   = in_i.control_byte;
    push_o.cmd.source_address = in_i.source_address;
    push_o.cmd.dest_offset    = in_i.dest_offset;
    push_o.cmd.double_speed   = in_i.double_speed;
  end

endmodule

// ===== design/hvd_queue.sv =====
// short command queue between the front end and the sequencer
// depends on hvd_pkg
`timescale 1ns / 1ps

module hvd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hvd_pkg::push_t push_i,
  input  logic           pop_i,
  output logic           full_o,
  output hvd_pkg::head_t head_o
);

  localparam int unsigned PtrW = $clog2(hvd_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(hvd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(hvd_pkg::QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(hvd_pkg::QUEUE_DEPTH);

  hvd_pkg::cmd_t   mem_q [hvd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

// ===== design/hvd_back.sv =====
// sequencer: holds the transfer state, runs the copy slots of each tick and
// drives the registered output word; depends on hvd_pkg and hvd_out_if
`timescale 1ns / 1ps

module hvd_back #(
  parameter int unsigned VRAM_END    = hvd_pkg::VRAM_END_DEF,
  parameter int unsigned BLOCK_BYTES = hvd_pkg::BLOCK_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hvd_pkg::head_t head_i,
  output logic           pop_o,
  hvd_out_if.source      out_o
);

  localparam int unsigned BlW  = $clog2(128 * BLOCK_BYTES + 1);
  localparam int unsigned BbW  = $clog2(BLOCK_BYTES + 1);
  localparam logic [BbW-1:0] BlockLoad = BbW'(BLOCK_BYTES);
  localparam logic [16:0]    VramLimit = 17'(VRAM_END);
  localparam logic [16:0]    VramBase  = 17'h08000;

  logic           active_q, active_d;
  logic           hmode_q, hmode_d;
  logic [BlW-1:0] bytes_q, bytes_d;
  logic [BbW-1:0] blk_q, blk_d;
  logic [15:0]    src_q, src_d;
  logic [12:0]    dst_q, dst_d;
  logic [7:0]     status_q, status_d;
  logic           second_q, second_d;
  logic           oval_q, oval_d;

  // result word staged into the output register
  logic        load;
  logic        r_copy, r_sw, r_last;
  logic [15:0] r_src, r_dst;
  logic [7:0]  r_sv;

  logic           out_free;
  logic [13:0]    next_off;
  logic [BlW-1:0] bytes_dec;
  logic [BbW-1:0] blk_dec;
  logic           stop;
  hvd_pkg::cmd_t  cmd;

  assign cmd      = head_i.cmd;
  assign out_free = !oval_q || out_o.ready;

  always_comb begin
    active_d = active_q;
    hmode_d  = hmode_q;
    bytes_d  = bytes_q;
    blk_d    = blk_q;
    src_d    = src_q;
    dst_d    = dst_q;
    status_d = status_q;
    second_d = second_q;
    pop_o    = 1'b0;
    load     = 1'b0;
    r_copy   = 1'b0;
    r_src    = '0;
    r_dst    = '0;
    r_sw     = 1'b0;
    r_sv     = '0;
    r_last   = 1'b0;
    stop     = 1'b0;

    next_off  = {1'b0, dst_q} + 14'd1;
    bytes_dec = (bytes_q != '0) ? bytes_q - 1'b1 : bytes_q;
    blk_dec   = (hmode_q && blk_q != '0) ? blk_q - 1'b1 : blk_q;

    if (head_i.valid) begin
      case (cmd.kind)
        hvd_pkg::CMD_START: begin
          if (out_free) begin
            pop_o    = 1'b1;
            bytes_d  = (BlW'({1'b0, cmd.control_byte[6:0]}) + 1'b1) * BlW'(BLOCK_BYTES);
            hmode_d  = cmd.control_byte[7];
            src_d    = cmd.source_address;
            dst_d    = cmd.dest_offset;
            blk_d    = cmd.control_byte[7] ? BlockLoad : '0;
            active_d = !cmd.control_byte[7];
            status_d = {1'b0, cmd.control_byte[6:0]};
            load     = 1'b1;
            r_sw     = 1'b1;
            r_sv     = {1'b0, cmd.control_byte[6:0]};
            r_last   = 1'b1;
          end
        end
        hvd_pkg::CMD_HBLANK: begin
          pop_o = 1'b1;
          if (hmode_q && !active_q && bytes_q != '0) begin
            active_d = 1'b1;
          end
        end
        default: begin
          if (!active_q) begin
            // tick with nothing to move
            pop_o    = 1'b1;
            second_d = 1'b0;
          end else if (out_free) begin
            load    = 1'b1;
            r_copy  = 1'b1;
            r_src   = src_q;
            r_dst   = {hvd_pkg::VRAM_BASE_HI, dst_q};
            src_d   = src_q + 16'd1;
            dst_d   = next_off[12:0];
            bytes_d = bytes_dec;
            blk_d   = blk_dec;
            if (bytes_dec == '0) begin
              active_d = 1'b0;
              hmode_d  = 1'b0;
              blk_d    = '0;
              status_d = hvd_pkg::STATUS_DONE;
              stop     = 1'b1;
            end else if (hmode_q && blk_dec == '0) begin
              // end of an hblank block: pause until the next hblank
              active_d = 1'b0;
              blk_d    = BlockLoad;
              status_d = {1'b0, status_q[6:0]} - 8'd1;
              stop     = 1'b1;
            end else if (VramBase + {3'b000, next_off} >= VramLimit) begin
              active_d = 1'b0;
              hmode_d  = 1'b0;
              blk_d    = '0;
              status_d = hvd_pkg::STATUS_DONE;
              stop     = 1'b1;
            end
            r_sw = stop;
            r_sv = stop ? status_d : 8'd0;
            if (stop || cmd.double_speed || second_q) begin
              pop_o    = 1'b1;
              r_last   = 1'b1;
              second_d = 1'b0;
            end else begin
              second_d = 1'b1;
            end
          end
        end
      endcase
    end

    if (load) begin
      oval_d = 1'b1;
    end else if (out_o.ready) begin
      oval_d = 1'b0;
    end else begin
      oval_d = oval_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      hmode_q  <= 1'b0;
      bytes_q  <= '0;
      blk_q    <= '0;
      src_q    <= '0;
      dst_q    <= '0;
      status_q <= hvd_pkg::STATUS_DONE;
      second_q <= 1'b0;
      oval_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      hmode_q  <= hmode_d;
      bytes_q  <= bytes_d;
      blk_q    <= blk_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
      status_q <= status_d;
      second_q <= second_d;
      oval_q   <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_o.copy_valid   <= r_copy;
      out_o.copy_source  <= r_src;
      out_o.copy_dest    <= r_dst;
      out_o.status_write <= r_sw;
      out_o.status_value <= r_sv;
      out_o.last         <= r_last;
    end
  end

  assign out_o.valid = oval_q;

endmodule

// ===== design/hblank_vram_dma_engine.sv =====
// an accepted word is queued first; its result word then goes into the output register
// throughput: one input word per cycle; a tick that copies two bytes holds the sequencer
// for two result words, the output register taking one per cycle while ready is high
// the four-entry command queue absorbs that, so input stalls only when it fills
// reset: asynchronous, active low; idle, status 0xff, queue empty, no output word
`timescale 1ns / 1ps

module hblank_vram_dma_engine #(
  parameter int unsigned VRAM_END    = hvd_pkg::VRAM_END_DEF,
  parameter int unsigned BLOCK_BYTES = hvd_pkg::BLOCK_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hvd_in_if.sink    in_i,
  hvd_out_if.source out_o
);

  hvd_pkg::push_t push;
  hvd_pkg::head_t head;
  logic           q_full;
  logic           pop;

  hvd_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  hvd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  hvd_back #(
    .VRAM_END    (VRAM_END),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// ===== design/hvd_checker.sv =====
// port-level checks of the dma engine, bound to the top level
// depends on the top level's interface ports
`timescale 1ns / 1ps

module hvd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        copy_valid_i,
  input logic [15:0] copy_source_i,
  input logic [15:0] copy_dest_i,
  input logic        status_write_i,
  input logic [7:0]  status_value_i,
  input logic        last_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_word_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(copy_source_i) && $stable(copy_dest_i)
      && $stable(status_value_i) && $stable(last_i))
    else $error("output word changed while stalled");

  // a word without a copy only comes from a start, which always writes status
  a_start_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !copy_valid_i |-> last_i && status_write_i
      && copy_source_i == 16'd0 && copy_dest_i == 16'd0 && !status_value_i[7])
    else $error("malformed start word");

  a_status_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !status_write_i |-> status_value_i == 8'd0)
    else $error("status value without status write");

  a_dest_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && copy_valid_i |-> copy_dest_i[15] && copy_dest_i[14:13] == 2'b00)
    else $error("copy destination outside video memory");

endmodule

bind hblank_vram_dma_engine hvd_checker u_hvd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .copy_valid_i   (out_o.copy_valid),
  .copy_source_i  (out_o.copy_source),
  .copy_dest_i    (out_o.copy_dest),
  .status_write_i (out_o.status_write),
  .status_value_i (out_o.status_value),
  .last_i         (out_o.last)
);

// ===== tb/hvd_dma_checker.sv =====
// checker for the hblank vram dma engine: watches both channels, predicts the
// result words and compares them in order; depends on hvd_pkg and the channel interfaces
`timescale 1ns / 1ps

module hvd_dma_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  hvd_in_if           in_mon_i,
  hvd_out_if          out_mon_i,
  output int unsigned mismatches_o,
  output int unsigned words_pending_o
);
  import hvd_pkg::*;

  localparam int unsigned VramEnd    = VRAM_END_DEF;
  localparam int unsigned BlockBytes = BLOCK_BYTES_DEF;

  typedef struct packed {
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] copy_dest;
    logic        status_write;
    logic [7:0]  status_value;
    logic        last;
  } dma_word_t;

  // shadow of the engine state
  logic        xfer_run  = 1'b0;
  logic        hb_mode   = 1'b0;
  logic [11:0] bytes_rem = '0;
  logic [4:0]  block_rem = '0;
  logic [15:0] src_ptr   = '0;
  logic [12:0] dst_ptr   = '0;
  logic [7:0]  status_q  = STATUS_DONE;

  dma_word_t   dma_words_due[$];
  int unsigned mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  task automatic predict_dma_words(input logic [1:0] op, input logic [7:0] cb,
                                   input logic [15:0] src, input logic [12:0] dst,
                                   input logic ds);
    dma_word_t   w;
    int unsigned slots;
    int unsigned first;
    logic [13:0] nxt;
    logic        stop;
    first = dma_words_due.size();
    case (op)
      OP_START: begin
        bytes_rem = 12'(({5'd0, cb[6:0]} + 12'd1) * BlockBytes);
        hb_mode   = cb[7];
        src_ptr   = src;
        dst_ptr   = dst;
        block_rem = cb[7] ? 5'(BlockBytes) : 5'd0;
        xfer_run  = !cb[7];
        status_q  = {1'b0, cb[6:0]};
        w = '0;
        w.status_write = 1'b1;
        w.status_value = status_q;
        dma_words_due.push_back(w);
      end
      OP_HBLANK: begin
        if (hb_mode && !xfer_run && bytes_rem != 0) xfer_run = 1'b1;
      end
      OP_TICK: begin
        if (xfer_run) begin
          slots = ds ? 1 : 2;
          for (int i = 0; i < slots; i++) begin
            w = '0;
            w.copy_valid  = 1'b1;
            w.copy_source = src_ptr;
            w.copy_dest   = 16'h8000 + {3'b000, dst_ptr};
            nxt  = {1'b0, dst_ptr} + 14'd1;
            stop = 1'b0;
            src_ptr = src_ptr + 16'd1;
            dst_ptr = nxt[12:0];
            if (bytes_rem != 0) bytes_rem = bytes_rem - 12'd1;
            if (hb_mode && block_rem != 0) block_rem = block_rem - 5'd1;
            if (bytes_rem == 0) begin
              xfer_run  = 1'b0;
              hb_mode   = 1'b0;
              block_rem = '0;
              status_q  = STATUS_DONE;
              stop      = 1'b1;
            end else if (hb_mode && block_rem == 0) begin
              // pause until the next hblank, one block fewer to go
              xfer_run  = 1'b0;
              block_rem = 5'(BlockBytes);
              status_q  = {1'b0, status_q[6:0]} - 8'd1;
              stop      = 1'b1;
            end else if (32'h8000 + 32'(nxt) >= VramEnd) begin
              xfer_run  = 1'b0;
              hb_mode   = 1'b0;
              block_rem = '0;
              status_q  = STATUS_DONE;
              stop      = 1'b1;
            end
            if (stop) begin
              w.status_write = 1'b1;
              w.status_value = status_q;
            end
            dma_words_due.push_back(w);
            if (stop) break;
          end
        end
      end
      default: ;
    endcase
    if (dma_words_due.size() > first) dma_words_due[$].last = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dma_word_t got;
    dma_word_t want;
    if (!rst_ni) begin
      xfer_run  <= 1'b0;
      hb_mode   <= 1'b0;
      bytes_rem <= '0;
      block_rem <= '0;
      src_ptr   <= '0;
      dst_ptr   <= '0;
      status_q  <= STATUS_DONE;
      dma_words_due.delete();
      words_pending_o <= 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready)
        predict_dma_words(in_mon_i.op, in_mon_i.control_byte, in_mon_i.source_address,
                          in_mon_i.dest_offset, in_mon_i.double_speed);
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.copy_valid   = out_mon_i.copy_valid;
        got.copy_source  = out_mon_i.copy_source;
        got.copy_dest    = out_mon_i.copy_dest;
        got.status_write = out_mon_i.status_write;
        got.status_value = out_mon_i.status_value;
        got.last         = out_mon_i.last;
        if (dma_words_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time, got);
          mismatch_cnt++;
        end else begin
          want = dma_words_due.pop_front();
          check_field("copy_valid", 16'(want.copy_valid), 16'(got.copy_valid));
          check_field("copy_source", want.copy_source, got.copy_source);
          check_field("copy_dest", want.copy_dest, got.copy_dest);
          check_field("status_write", 16'(want.status_write), 16'(got.status_write));
          check_field("status_value", 16'(want.status_value), 16'(got.status_value));
          check_field("last", 16'(want.last), 16'(got.last));
        end
      end
      words_pending_o <= dma_words_due.size();
    end
  end

endmodule

// ===== tb/tb_hblank_vram_dma_engine.sv =====
// testbench top for the hblank vram dma engine: clock, reset, stimulus and verdict
// depends on hvd_pkg, the channel interfaces, the engine and hvd_dma_checker
`timescale 1ns / 1ps

module tb_hblank_vram_dma_engine;
  import hvd_pkg::*;

  localparam int unsigned TargetItems = 1700;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hvd_in_if  in_ch ();
  hvd_out_if out_ch ();

  int unsigned mismatches;
  int unsigned words_pending;
  int unsigned work_items = 0;
  bit          jitter_on     = 1'b1;
  bit          long_hold_req = 1'b0;

  always #4 clk_i = ~clk_i;

  hblank_vram_dma_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  hvd_dma_checker u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon_i        (in_ch),
    .out_mon_i       (out_ch),
    .mismatches_o    (mismatches),
    .words_pending_o (words_pending)
  );

  // mostly short idle stretches, a few long ones
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_word(input logic [1:0] op, input logic [7:0] cb,
                            input logic [15:0] src, input logic [12:0] dst,
                            input logic ds);
    int unsigned gap;
    gap = 0;
    if (jitter_on && $urandom_range(0, 99) >= 55) gap = idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.control_byte   <= cb;
    in_ch.source_address <= src;
    in_ch.dest_offset    <= dst;
    in_ch.double_speed   <= ds;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (op == OP_START || op == OP_TICK) work_items++;
    @(negedge clk_i);
  endtask

  task automatic tick(input logic ds);
    drive_word(OP_TICK, 8'($urandom), 16'($urandom), 13'($urandom), ds);
  endtask

  task automatic hblank_begin();
    drive_word(OP_HBLANK, 8'($urandom), 16'($urandom), 13'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (words_pending != 0) @(negedge clk_i);
  endtask

  // one start followed by mostly well-formed ticks and hblank events
  task automatic run_transfer();
    int unsigned r;
    int unsigned blocks;
    int unsigned done_bytes;
    int unsigned blk_bytes;
    int unsigned ticks;
    int unsigned cap;
    logic [7:0]  cb;
    logic [12:0] dst;
    logic        ds;
    r = $urandom_range(0, 99);
    if (r < 85) cb[6:0] = 7'($urandom_range(0, 3));
    else if (r < 98) cb[6:0] = 7'($urandom_range(4, 15));
    else cb[6:0] = 7'($urandom_range(16, 127));
    cb[7] = 1'($urandom);
    blocks = cb[6:0] + 1;
    // some transfers run into the end of video memory
    if ($urandom_range(0, 99) < 30) dst = 13'(8192 - $urandom_range(1, 40));
    else dst = 13'($urandom);
    drive_word(OP_START, cb, 16'($urandom), dst, 1'($urandom));
    cap = $urandom_range(40, 160);
    ticks = 0;
    done_bytes = 0;
    if (cb[7]) begin
      for (int b = 0; b < blocks && ticks < cap; b++) begin
        if ($urandom_range(0, 9) == 0) tick(1'($urandom));
        if ($urandom_range(0, 19) != 0) hblank_begin();
        blk_bytes = 0;
        while (blk_bytes < 16 && ticks < cap) begin
          ds = ($urandom_range(0, 3) == 0);
          tick(ds);
          blk_bytes += ds ? 1 : 2;
          ticks++;
        end
        if ($urandom_range(0, 19) == 0) break;
      end
    end else begin
      while (done_bytes < blocks * 16 && ticks < cap) begin
        ds = ($urandom_range(0, 3) == 0);
        tick(ds);
        done_bytes += ds ? 1 : 2;
        ticks++;
        if ($urandom_range(0, 99) == 0) break;
      end
    end
    if ($urandom_range(0, 3) == 0) tick(1'($urandom));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(2, 6))
      drive_word(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 13'($urandom),
                 1'($urandom));
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 299;
        out_ch.ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 99) < 15) begin
        hold_left = idle_len() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned r;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_TICK;
    in_ch.control_byte   = '0;
    in_ch.source_address = '0;
    in_ch.dest_offset    = '0;
    in_ch.double_speed   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // idle engine: tick, unused op and hblank are all ignored
    drive_word(OP_TICK, 8'h00, 16'h0000, 13'h0000, 1'b0);
    drive_word(2'd3, 8'hFF, 16'hFFFF, 13'h1FFF, 1'b1);
    drive_word(OP_HBLANK, 8'h00, 16'h0000, 13'h0000, 1'b0);
    // general mode up to the last byte, ending in the first slot of a tick
    drive_word(OP_START, 8'h00, 16'h1234, 13'h0000, 1'b0);
    tick(1'b1);
    repeat (8) tick(1'b0);
    // hblank mode up to a block end, source wrapping on the way
    drive_word(OP_START, 8'h81, 16'hFFFC, 13'h0100, 1'b1);
    hblank_begin();
    repeat (8) tick(1'b0);
    // largest length in hblank mode, stopped by the end of video memory
    drive_word(OP_START, 8'hFF, 16'h0000, 13'h1FFF, 1'b0);
    hblank_begin();
    tick(1'b1);

    // long receiver hold-off while ticks keep coming
    jitter_on = 1'b0;
    long_hold_req = 1'b1;
    drive_word(OP_START, 8'h7F, 16'($urandom), 13'h0000, 1'b0);
    repeat (60) tick(1'b0);
    drain();

    while (work_items < TargetItems) begin
      jitter_on = ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 99);
      if (r < 78) run_transfer();
      else if (r < 94) run_noise();
      else drain();
    end

    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (words_pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && words_pending == 0) begin
      $display("tb_hblank_vram_dma_engine: clean");
    end else begin
      $display("tb_hblank_vram_dma_engine: errors");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("tb_hblank_vram_dma_engine: errors");
    $finish;
  end

endmodule
